// ===== design/wrms_pkg.sv =====
// Shared types and constants for the weighted random member selector.
`timescale 1ns / 1ps

package wrms_pkg;

    localparam int MAX_MEMBERS_DEF = 64;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int ID_W        = 32;
    localparam int WEIGHT_IN_W = 16;
    localparam int TOTAL_W     = 22;
    localparam int INDEX_OUT_W = 6;

    localparam logic [TOTAL_W-1:0] SUM_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_APPEND   = 2'd1,
        OP_SET_LAST = 2'd2,
        OP_SELECT   = 2'd3
    } t_opcode;

endpackage

// ===== design/weighted_random_member_select.sv =====
// Weighted random member selector: member table in memories, roulette walk on select.
// Clear and append update count and total on transfer; set last weight passes S_FIX (old weight read).
// Select: S_WALK from index 0 to the chosen index, then S_EMIT; straight to S_EMIT when not found.
// Throughput: one select at a time, set by one weight read a cycle; S_EMIT waits while a result is held.
// Clear and append follow every cycle while the block is idle, also while a result waits.
// Reset: synchronous, active low; clears count, total and control; memories are not cleared.
`timescale 1ns / 1ps

module weighted_random_member_select
    import wrms_pkg::*;
#(
    parameter int MAX_MEMBERS = MAX_MEMBERS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_opcode,
    input  logic [ID_W-1:0]        i_member_id,
    input  logic [WEIGHT_IN_W-1:0] i_weight,
    input  logic [TOTAL_W-1:0]     i_draw,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_found,
    output logic [INDEX_OUT_W-1:0] o_chosen_index,
    output logic [ID_W-1:0]        o_chosen_id,
    output logic [TOTAL_W-1:0]     o_total
);

    localparam int IDXW    = $clog2(MAX_MEMBERS);
    localparam int CNTW    = $clog2(MAX_MEMBERS + 1);
    localparam int SUMW_A  = WEIGHT_BITS + CNTW;
    localparam int SUMW    = (SUMW_A > TOTAL_W + 1) ? SUMW_A : TOTAL_W + 1;
    localparam int WXW     = (WEIGHT_BITS > WEIGHT_IN_W) ? WEIGHT_BITS : WEIGHT_IN_W;
    localparam int PXW     = (IDXW > INDEX_OUT_W) ? IDXW : INDEX_OUT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIX,
        S_WALK,
        S_EMIT
    } t_state;

    logic [WEIGHT_BITS-1:0] weight_mem [MAX_MEMBERS];
    logic [ID_W-1:0]        id_mem     [MAX_MEMBERS];

    t_state                 r_state;
    logic [CNTW-1:0]        r_count;
    logic [SUMW-1:0]        r_true_sum;
    logic [WEIGHT_BITS-1:0] r_new_w;
    logic [WEIGHT_BITS-1:0] r_w_q;
    logic [ID_W-1:0]        r_id_q;
    logic [SUMW-1:0]        r_cum;
    logic [IDXW-1:0]        r_idx;
    logic [TOTAL_W-1:0]     r_draw;
    logic                   r_res_found;
    logic [IDXW-1:0]        r_res_index;
    logic [ID_W-1:0]        r_res_id;
    logic [TOTAL_W-1:0]     r_res_total;
    logic                   r_out_valid;
    logic                   r_o_found;
    logic [INDEX_OUT_W-1:0] r_o_index;
    logic [ID_W-1:0]        r_o_id;
    logic [TOTAL_W-1:0]     r_o_total;

    logic                   in_xfer;
    logic [WXW-1:0]         w_ext;
    logic [WEIGHT_BITS-1:0] w_in;
    logic [TOTAL_W-1:0]     total_sat;
    logic                   full;
    logic                   eligible;
    logic [CNTW-1:0]        cnt_m1;
    logic [IDXW-1:0]        last_addr;
    logic [IDXW-1:0]        app_addr;
    logic [SUMW-1:0]        n_cum;
    logic                   hit;
    logic [PXW-1:0]         idx_ext;
    logic                   w_we;
    logic                   id_we;
    logic [IDXW-1:0]        wr_addr;
    logic                   rd_en;
    logic [IDXW-1:0]        rd_addr;
    t_opcode                op;

    assign op         = t_opcode'(i_opcode);
    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign w_ext      = WXW'(i_weight);
    assign w_in       = w_ext[WEIGHT_BITS-1:0];
    assign total_sat  = (r_true_sum > SUMW'(SUM_MAX)) ? SUM_MAX : r_true_sum[TOTAL_W-1:0];
    assign full       = (r_count == CNTW'(MAX_MEMBERS));
    assign eligible   = (r_count != '0) && (i_draw < total_sat);
    assign cnt_m1     = r_count - CNTW'(1);
    assign last_addr  = cnt_m1[IDXW-1:0];
    assign app_addr   = r_count[IDXW-1:0];
    assign n_cum      = r_cum + SUMW'(r_w_q);
    assign hit        = (n_cum > SUMW'(r_draw));
    assign idx_ext    = PXW'(r_res_index);

    always_comb begin
        w_we    = 1'b0;
        id_we   = 1'b0;
        wr_addr = app_addr;
        rd_en   = 1'b0;
        rd_addr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    unique case (op)
                        OP_APPEND: begin
                            w_we  = !full;
                            id_we = !full;
                        end
                        OP_SET_LAST: begin
                            w_we    = (r_count != '0);
                            wr_addr = last_addr;
                            rd_en   = (r_count != '0);
                            rd_addr = last_addr;
                        end
                        OP_SELECT: begin
                            rd_en   = eligible;
                            rd_addr = '0;
                        end
                        OP_CLEAR: begin
                            w_we = 1'b0;
                        end
                    endcase
                end
            end
            S_WALK: begin
                rd_en   = !hit;
                rd_addr = r_idx + IDXW'(1);
            end
            S_FIX, S_EMIT: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            weight_mem[wr_addr] <= w_in;
        end
        if (id_we) begin
            id_mem[wr_addr] <= i_member_id;
        end
        if (rd_en) begin
            r_w_q  <= weight_mem[rd_addr];
            r_id_q <= id_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_true_sum  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        unique case (op)
                            OP_CLEAR: begin
                                r_count    <= '0;
                                r_true_sum <= '0;
                            end
                            OP_APPEND: begin
                                if (!full) begin
                                    r_count    <= r_count + CNTW'(1);
                                    r_true_sum <= r_true_sum + SUMW'(w_in);
                                end
                            end
                            OP_SET_LAST: begin
                                if (r_count != '0) begin
                                    r_new_w <= w_in;
                                    r_state <= S_FIX;
                                end
                            end
                            OP_SELECT: begin
                                r_res_total <= total_sat;
                                r_res_found <= 1'b0;
                                r_res_index <= '0;
                                r_res_id    <= '0;
                                r_cum       <= '0;
                                r_idx       <= '0;
                                r_draw      <= i_draw;
                                r_state     <= eligible ? S_WALK : S_EMIT;
                            end
                        endcase
                    end
                end
                S_FIX: begin
                    r_true_sum <= r_true_sum - SUMW'(r_w_q) + SUMW'(r_new_w);
                    r_state    <= S_IDLE;
                end
                S_WALK: begin
                    if (hit) begin
                        r_res_found <= 1'b1;
                        r_res_index <= r_idx;
                        r_res_id    <= r_id_q;
                        r_state     <= S_EMIT;
                    end else begin
                        r_cum <= n_cum;
                        r_idx <= r_idx + IDXW'(1);
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_o_found   <= r_res_found;
                        r_o_index   <= idx_ext[INDEX_OUT_W-1:0];
                        r_o_id      <= r_res_id;
                        r_o_total   <= r_res_total;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_o_found;
    assign o_chosen_index = r_o_index;
    assign o_chosen_id    = r_o_id;
    assign o_total        = r_o_total;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_MEMBERS))
        else $error("member count beyond table depth");

    a_walk_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (CNTW'(r_idx) < r_count))
        else $error("select walk ran past the last member");

    a_select_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (op == OP_SELECT)) |=> (r_state == S_WALK || r_state == S_EMIT))
        else $error("select transfer did not start a walk or a result");

    a_empty_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_true_sum == '0))
        else $error("empty table with nonzero total");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the weighted random member selector.
`timescale 1ns / 1ps

module testbench;
    import wrms_pkg::*;

    localparam int MEMBERS     = MAX_MEMBERS_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        t_opcode                op;
        logic [ID_W-1:0]        member_id;
        logic [WEIGHT_IN_W-1:0] weight;
        logic [TOTAL_W-1:0]     draw;
        logic                   drain;
    } roster_cmd_t;

    typedef struct packed {
        logic                   found;
        logic [INDEX_OUT_W-1:0] index;
        logic [ID_W-1:0]        id;
        logic [TOTAL_W-1:0]     total;
    } pick_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic [1:0]             i_opcode = '0;
    logic [ID_W-1:0]        i_member_id = '0;
    logic [WEIGHT_IN_W-1:0] i_weight = '0;
    logic [TOTAL_W-1:0]     i_draw = '0;
    logic                   i_out_ready = 1'b0;
    wire                    o_in_ready;
    wire                    o_out_valid;
    wire                    o_found;
    wire [INDEX_OUT_W-1:0]  o_chosen_index;
    wire [ID_W-1:0]         o_chosen_id;
    wire [TOTAL_W-1:0]      o_total;

    roster_cmd_t cmd_q[$];
    pick_t       pick_due_q[$];
    roster_cmd_t cur_cmd;

    logic [WEIGHT_IN_W-1:0] roster_wt [MEMBERS];
    logic [ID_W-1:0]        roster_id [MEMBERS];
    int                     roster_count = 0;
    logic [TOTAL_W-1:0]     roster_total = '0;

    int gen_count = 0;
    int gen_sum = 0;
    int gen_last = 0;
    logic drain_next = 1'b0;

    int  in_count = 0;
    int  error_count = 0;
    int  stall_cycles = 0;
    int  hold_left = 0;
    int  hold_phase = 0;
    wire idle_on = (in_count < 300) || (in_count >= 500);

    weighted_random_member_select u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_member_id    (i_member_id),
        .i_weight       (i_weight),
        .i_draw         (i_draw),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_chosen_index (o_chosen_index),
        .o_chosen_id    (o_chosen_id),
        .o_total        (o_total)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [TOTAL_W-1:0] clip_total(input int v);
        return (v > int'(SUM_MAX)) ? SUM_MAX : v[TOTAL_W-1:0];
    endfunction

    task automatic roster_update(input roster_cmd_t c);
        int    k;
        int    acc;
        logic  hit;
        pick_t r;
        acc = 0;
        hit = 1'b0;
        r = '0;
        case (c.op)
            OP_CLEAR: begin
                roster_count = 0;
                roster_total = '0;
            end
            OP_APPEND: begin
                if (roster_count < MEMBERS) begin
                    roster_wt[roster_count] = c.weight;
                    roster_id[roster_count] = c.member_id;
                    roster_count++;
                    roster_total = clip_total(int'(roster_total) + int'(c.weight));
                end
            end
            OP_SET_LAST: begin
                if (roster_count > 0) begin
                    roster_wt[roster_count-1] = c.weight;
                    for (k = 0; k < roster_count; k++) acc += int'(roster_wt[k]);
                    roster_total = clip_total(acc);
                end
            end
            default: begin
                r.total = roster_total;
                if (roster_count > 0 && c.draw < roster_total) begin
                    for (k = 0; k < roster_count && !hit; k++) begin
                        acc += int'(roster_wt[k]);
                        if (acc > int'(c.draw)) begin
                            hit = 1'b1;
                            r.found = 1'b1;
                            r.index = k[INDEX_OUT_W-1:0];
                            r.id = roster_id[k];
                        end
                    end
                end
                pick_due_q.push_back(r);
            end
        endcase
    endtask

    task automatic queue_cmd(input t_opcode op, input logic [ID_W-1:0] id,
                             input logic [WEIGHT_IN_W-1:0] w, input logic [TOTAL_W-1:0] d);
        roster_cmd_t c;
        c.op = op;
        c.member_id = id;
        c.weight = w;
        c.draw = d;
        c.drain = drain_next;
        drain_next = 1'b0;
        cmd_q.push_back(c);
        case (op)
            OP_CLEAR: begin
                gen_count = 0;
                gen_sum = 0;
            end
            OP_APPEND: begin
                if (gen_count < MEMBERS) begin
                    gen_count++;
                    gen_sum += int'(w);
                    gen_last = int'(w);
                end
            end
            OP_SET_LAST: begin
                if (gen_count > 0) begin
                    gen_sum = gen_sum - gen_last + int'(w);
                    gen_last = int'(w);
                end
            end
            default: ;
        endcase
    endtask

    function automatic logic [WEIGHT_IN_W-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        if (r < 50) return WEIGHT_IN_W'($urandom_range(1, 15));
        return WEIGHT_IN_W'($urandom);
    endfunction

    function automatic logic [TOTAL_W-1:0] pick_draw();
        int r;
        int cap;
        r = $urandom_range(0, 99);
        cap = (gen_sum > int'(SUM_MAX)) ? int'(SUM_MAX) : gen_sum;
        if (cap > 0 && r < 75) return TOTAL_W'($urandom_range(0, cap - 1));
        if (cap > 0 && r < 85) return TOTAL_W'(cap - 1);
        if (r < 90) return '0;
        if (r < 95) return TOTAL_W'(cap);
        return TOTAL_W'($urandom);
    endfunction

    initial begin : stim_main
        int seq_no;
        int n;
        int k;
        int r;
        seq_no = 0;

        queue_cmd(OP_SELECT, '0, '0, '0);
        queue_cmd(OP_SET_LAST, '0, 16'd5, '0);
        queue_cmd(OP_SELECT, '0, '0, '0);
        queue_cmd(OP_APPEND, '1, '0, '0);
        queue_cmd(OP_SELECT, '0, '0, '0);
        queue_cmd(OP_APPEND, '0, '1, '1);
        queue_cmd(OP_SELECT, '0, '0, '0);
        queue_cmd(OP_SELECT, '1, '1, 22'h00FFFE);
        queue_cmd(OP_SELECT, '0, '0, 22'h00FFFF);
        queue_cmd(OP_SELECT, '0, '0, '1);
        queue_cmd(OP_APPEND, 32'hA5A5A5A5, 16'd1, '0);
        queue_cmd(OP_SELECT, '0, '0, 22'h00FFFF);
        queue_cmd(OP_SET_LAST, '0, '0, '0);
        queue_cmd(OP_SELECT, '0, '0, 22'h00FFFF);
        queue_cmd(OP_SET_LAST, '0, 16'd3, '0);
        queue_cmd(OP_SELECT, '0, '0, 22'h010001);
        queue_cmd(OP_CLEAR, '1, '1, '1);
        queue_cmd(OP_SELECT, '0, '0, '0);
        queue_cmd(OP_APPEND, 32'h12345678, 16'd7, '0);
        queue_cmd(OP_SELECT, '0, '0, 22'd6);
        drain_next = 1'b1;

        while (cmd_q.size() < 820) begin
            r = $urandom_range(0, 99);
            if (seq_no == 3 || r < 3) begin
                queue_cmd(OP_CLEAR, $urandom, WEIGHT_IN_W'($urandom), TOTAL_W'($urandom));
                for (k = 0; k < MEMBERS + 2; k++) begin
                    queue_cmd(OP_APPEND, $urandom,
                              ($urandom_range(0, 3) == 0) ? '1 : pick_weight(),
                              TOTAL_W'($urandom));
                end
                for (k = 0; k < 4; k++) begin
                    queue_cmd(OP_SELECT, $urandom, WEIGHT_IN_W'($urandom), pick_draw());
                end
                queue_cmd(OP_SET_LAST, $urandom, pick_weight(), TOTAL_W'($urandom));
                queue_cmd(OP_SELECT, $urandom, WEIGHT_IN_W'($urandom), pick_draw());
            end else if (r < 85) begin
                queue_cmd(OP_CLEAR, $urandom, WEIGHT_IN_W'($urandom), TOTAL_W'($urandom));
                n = $urandom_range(1, 8);
                for (k = 0; k < n; k++) begin
                    queue_cmd(OP_APPEND, $urandom, pick_weight(), TOTAL_W'($urandom));
                end
                n = $urandom_range(2, 6);
                for (k = 0; k < n; k++) begin
                    if ($urandom_range(0, 4) == 0) begin
                        queue_cmd(OP_SET_LAST, $urandom, pick_weight(), TOTAL_W'($urandom));
                    end
                    if ($urandom_range(0, 5) == 0) begin
                        queue_cmd(OP_APPEND, $urandom, pick_weight(), TOTAL_W'($urandom));
                    end
                    queue_cmd(OP_SELECT, $urandom, WEIGHT_IN_W'($urandom), pick_draw());
                end
            end else begin
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++) begin
                    queue_cmd(t_opcode'($urandom_range(0, 3)), $urandom,
                              WEIGHT_IN_W'($urandom), TOTAL_W'($urandom));
                end
            end
            if (seq_no == 40) drain_next = 1'b1;
            seq_no++;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() != 0 || i_in_valid || pick_due_q.size() != 0) @(posedge i_clk);
        repeat (MEMBERS + 8) @(posedge i_clk);

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                roster_update(cur_cmd);
                in_count <= in_count + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (cmd_q.size() != 0 && !(cmd_q[0].drain && pick_due_q.size() != 0)
                        && !(idle_on && $urandom_range(0, 99) < 19)) begin
                    cur_cmd = cmd_q.pop_front();
                    i_in_valid  <= 1'b1;
                    i_opcode    <= cur_cmd.op;
                    i_member_id <= cur_cmd.member_id;
                    i_weight    <= cur_cmd.weight;
                    i_draw      <= cur_cmd.draw;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if ((hold_phase == 0 && in_count >= 250) ||
                     (hold_phase == 1 && in_count >= 650)) begin
            hold_phase  <= hold_phase + 1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !(idle_on && $urandom_range(0, 99) < 19);
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (error_count < 100) begin
            $display("mismatch %s: got %0h, expected %0h", what, got, want);
        end
        error_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        pick_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pick_due_q.size() == 0) begin
                report_mismatch("unexpected transfer", o_found, 0);
            end else begin
                want = pick_due_q.pop_front();
                if (o_found !== want.found) report_mismatch("found", o_found, want.found);
                if (o_chosen_index !== want.index) begin
                    report_mismatch("chosen_index", o_chosen_index, want.index);
                end
                if (o_chosen_id !== want.id) report_mismatch("chosen_id", o_chosen_id, want.id);
                if (o_total !== want.total) report_mismatch("total", o_total, want.total);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule

// ===== sim.f =====
design/wrms_pkg.sv
design/weighted_random_member_select.sv
test/testbench.sv
